[rtl/core/dge_pkg.sv]
// Package for the dual-gradient energy block.
// Holds the sequencer state type, register indexes and result slot codes.
// No dependencies.
package dge_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_WR0,
        ST_WR1,
        ST_WR2,
        ST_PICK,
        ST_SUM,
        ST_ROOT,
        ST_OUT,
        ST_DONE
    } t_state;

    // Configuration register indexes
    localparam logic [7:0] CFG_IMAGE_WIDTH  = 8'd0;
    localparam logic [7:0] CFG_IMAGE_HEIGHT = 8'd1;

    // Result slots within one input transaction, in emission order
    typedef enum logic [1:0] {
        RES_UP_LEFT  = 2'd0,  // row above, column to the left
        RES_UP_END   = 2'd1,  // row above, last column
        RES_CUR_LEFT = 2'd2,  // last row, column to the left
        RES_CUR_END  = 2'd3   // last row, last column
    } t_slot;

    localparam int unsigned CFG_W  = 11;
    localparam int unsigned PIX_W  = 24;
    localparam int unsigned SUM_W  = 19;
    localparam int unsigned ROOT_W = 31;

endpackage

[rtl/core/dge_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// Used for both line buffers of the energy block. No dependencies.
module dge_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/dual_gradient_energy.sv]
// Top level of the dual-gradient energy block (seam carving energy).
// Depends on dge_pkg and two instances of dge_ram (line buffers).
//
//  Channel | Direction | Handshake                    | Payload
//  --------+-----------+------------------------------+-------------------------------------
//  in      | sink      | i_in_valid / o_in_ready      | i_red, i_green, i_blue
//  out     | source    | o_out_valid / i_out_ready    | o_energy_q, o_square_sum, o_out_row,
//          |           |                              | o_out_column, o_last_of_run,
//          |           |                              | o_frame_done
//  cfg     | sink      | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// Sequence: accept, line-buffer reads (ST_RD0..ST_RD2) and writes (ST_WR0..ST_WR2), then per result
// (0..4) a select, a sum over red, green and blue, a bit-serial root (one result bit per cycle)
// and an output state held until the result is taken, then a final select and a bookkeeping state.
// Reset: synchronous, active low; clears counts and recent pixels, sets the size registers to 1024.
// The line buffers are not cleared. Stalls on the output hold the sequencer in place.
module dual_gradient_energy #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // pixel input
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [7:0]                   i_red,
    input  logic [7:0]                   i_green,
    input  logic [7:0]                   i_blue,
    // energy output
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [15:0]                  o_energy_q,
    output logic [18:0]                  o_square_sum,
    output logic [9:0]                   o_out_row,
    output logic [9:0]                   o_out_column,
    output logic                         o_last_of_run,
    output logic                         o_frame_done,
    // configuration writes
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [7:0]                   i_cfg_index,
    input  logic [dge_pkg::CFG_W-1:0]    i_cfg_data
);
    import dge_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_cfg_w;
    logic [CFG_W-1:0] r_cfg_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_W'(1024);
            r_cfg_h <= CFG_W'(1024);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_IMAGE_WIDTH) begin
                r_cfg_w <= i_cfg_data;
            end else if (i_cfg_index == CFG_IMAGE_HEIGHT) begin
                r_cfg_h <= i_cfg_data;
            end
        end
    end

    // Effective size: zero means one, above the maximum saturates.
    logic [CW:0] w_eff;
    logic [RW:0] h_eff;

    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = (CW+1)'(1);
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            w_eff = (CW+1)'(MAX_WIDTH);
        end else begin
            w_eff = (CW+1)'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_eff = (RW+1)'(1);
        end else if (32'(r_cfg_h) > 32'(MAX_HEIGHT)) begin
            h_eff = (RW+1)'(MAX_HEIGHT);
        end else begin
            h_eff = (RW+1)'(r_cfg_h);
        end
    end

    // ------------------------------------------------------------------
    // Position and per-transaction registers
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    logic [CW-1:0]       r_col;
    logic [RW-1:0]       r_row;
    logic [CW-1:0]       r_c;        // saturated column of the current pixel
    logic [RW-1:0]       r_r;        // saturated row of the current pixel
    logic                r_end;
    logic                r_lastrow;
    logic [PIX_W-1:0]    r_cur;
    logic [PIX_W-1:0]    r_prev0;    // pixel one to the left
    logic [PIX_W-1:0]    r_prev1;    // pixel two to the left
    logic [PIX_W-1:0]    r_pm2, r_pm1, r_pc;   // previous row at c-2, c-1, c
    logic [PIX_W-1:0]    r_om1, r_oc;          // older row at c-1, c
    logic [3:0]          r_pend;
    t_slot               r_slot;
    logic [1:0]          r_ch;
    logic [SUM_W-1:0]    r_sum;
    logic [ROOT_W-1:0]   r_sq_v;
    logic [31:0]         r_sq_res;
    logic [ROOT_W-1:0]   r_sq_bit;

    logic [CW-1:0] c_now;
    logic [RW-1:0] r_now;
    logic          end_now, last_now, in_fire;

    assign in_fire = i_in_valid && o_in_ready;

    always_comb begin
        if ({1'b0, r_col} < w_eff) begin
            c_now = r_col;
        end else begin
            c_now = CW'(w_eff - 1'b1);
        end
        if ({1'b0, r_row} < h_eff) begin
            r_now = r_row;
        end else begin
            r_now = RW'(h_eff - 1'b1);
        end
        end_now  = ({1'b0, c_now} == w_eff - 1'b1);
        last_now = ({1'b0, r_now} == h_eff - 1'b1);
    end

    logic c_ge1, c_ge2, r_ge1, r_ge2;
    assign c_ge1 = (r_c != '0);
    assign c_ge2 = (r_c >= CW'(2));
    assign r_ge1 = (r_r != '0);
    assign r_ge2 = (r_r >= RW'(2));

    // ------------------------------------------------------------------
    // Line buffers
    // ------------------------------------------------------------------
    logic              p_we, o_we;
    logic [CW-1:0]     p_waddr, p_raddr, o_waddr, o_raddr;
    logic [PIX_W-1:0]  p_wdata, o_wdata, p_rdata, o_rdata;

    dge_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prev_row (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    dge_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_row (
        .i_clk   (i_clk),
        .i_we    (o_we),
        .i_waddr (o_waddr),
        .i_wdata (o_wdata),
        .i_raddr (o_raddr),
        .o_rdata (o_rdata)
    );

    // Reads finish before any write of the same transaction, and all writes
    // land before the next pixel is taken, so no forwarding is needed.
    always_comb begin
        p_we    = 1'b0;
        o_we    = 1'b0;
        p_waddr = r_c;
        o_waddr = r_c;
        p_wdata = r_cur;
        o_wdata = r_pc;
        p_raddr = r_c;
        o_raddr = r_c;
        unique case (r_state)
            ST_RD0: begin
                p_raddr = c_ge2 ? r_c - CW'(2) : '0;
                o_raddr = c_ge1 ? r_c - 1'b1 : '0;
            end
            ST_RD1: begin
                p_raddr = c_ge1 ? r_c - 1'b1 : '0;
                o_raddr = r_c;
            end
            ST_RD2: begin
                p_raddr = r_c;
            end
            ST_WR0: begin
                // previous[c-2] <= pixel two left, older[c-1] <= previous[c-1]
                p_we    = c_ge2;
                p_waddr = r_c - CW'(2);
                p_wdata = r_prev1;
                o_we    = c_ge1;
                o_waddr = r_c - 1'b1;
                o_wdata = r_pm1;
            end
            ST_WR1: begin
                p_we    = r_end && c_ge1;
                p_waddr = r_c - 1'b1;
                p_wdata = r_prev0;
                o_we    = r_end;
                o_waddr = r_c;
                o_wdata = r_pc;
            end
            ST_WR2: begin
                p_we    = r_end;
                p_waddr = r_c;
                p_wdata = r_cur;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Operand selection for the current result slot
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] op_l, op_r, op_u, op_d;

    always_comb begin
        case (r_slot)
            RES_UP_LEFT: begin
                op_l = c_ge2 ? r_pm2 : r_pm1;
                op_r = r_pc;
                op_u = r_ge2 ? r_om1 : r_pm1;
                op_d = r_prev0;
            end
            RES_UP_END: begin
                op_l = c_ge1 ? r_pm1 : r_pc;
                op_r = r_pc;
                op_u = r_ge2 ? r_oc : r_pc;
                op_d = r_cur;
            end
            RES_CUR_LEFT: begin
                op_l = c_ge2 ? r_prev1 : r_prev0;
                op_r = r_cur;
                op_u = r_ge1 ? r_pm1 : r_prev0;
                op_d = r_prev0;
            end
            default: begin
                op_l = c_ge1 ? r_prev0 : r_cur;
                op_r = r_cur;
                op_u = r_ge1 ? r_pc : r_cur;
                op_d = r_cur;
            end
        endcase
    end

    // One channel per cycle: red, green, blue.
    logic [7:0]        ch_l, ch_r, ch_u, ch_d;
    logic signed [8:0] dx, dy;
    logic signed [17:0] sx, sy;
    logic [SUM_W-1:0]  n_sum;

    always_comb begin
        case (r_ch)
            2'd0: begin
                ch_l = op_l[23:16]; ch_r = op_r[23:16];
                ch_u = op_u[23:16]; ch_d = op_d[23:16];
            end
            2'd1: begin
                ch_l = op_l[15:8];  ch_r = op_r[15:8];
                ch_u = op_u[15:8];  ch_d = op_d[15:8];
            end
            default: begin
                ch_l = op_l[7:0];   ch_r = op_r[7:0];
                ch_u = op_u[7:0];   ch_d = op_d[7:0];
            end
        endcase
        dx    = $signed({1'b0, ch_r}) - $signed({1'b0, ch_l});
        dy    = $signed({1'b0, ch_d}) - $signed({1'b0, ch_u});
        sx    = dx * dx;
        sy    = dy * dy;
        n_sum = ((r_ch == 2'd0) ? '0 : r_sum) + SUM_W'($unsigned(sx))
                + SUM_W'($unsigned(sy));
    end

    // Square root step: one result bit per cycle.
    logic [31:0] sq_trial;
    logic        sq_take;
    assign sq_trial = r_sq_res + 32'(r_sq_bit);
    assign sq_take  = (32'(r_sq_v) >= sq_trial);

    // Lowest pending slot
    logic [1:0] pick_idx;
    always_comb begin
        if (r_pend[0]) begin
            pick_idx = 2'd0;
        end else if (r_pend[1]) begin
            pick_idx = 2'd1;
        end else if (r_pend[2]) begin
            pick_idx = 2'd2;
        end else begin
            pick_idx = 2'd3;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_fire) n_state = ST_RD0;
            ST_RD0:  n_state = ST_RD1;
            ST_RD1:  n_state = ST_RD2;
            ST_RD2:  n_state = ST_WR0;
            ST_WR0:  n_state = ST_WR1;
            ST_WR1:  n_state = ST_WR2;
            ST_WR2:  n_state = ST_PICK;
            ST_PICK: n_state = (r_pend == '0) ? ST_DONE : ST_SUM;
            ST_SUM:  if (r_ch == 2'd2) n_state = ST_ROOT;
            ST_ROOT: if (r_sq_bit[0]) n_state = ST_OUT;
            ST_OUT:  if (i_out_ready) n_state = ST_PICK;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_prev0 <= '0;
            r_prev1 <= '0;
            r_pend  <= '0;
            r_ch    <= '0;
        end else begin
            if (in_fire) begin
                r_pend <= {last_now && end_now, last_now && (c_now != '0),
                           (r_now != '0) && end_now, (r_now != '0) && (c_now != '0)};
            end
            if (r_state == ST_PICK && r_pend != '0) begin
                r_pend[pick_idx] <= 1'b0;
                r_ch             <= '0;
            end
            if (r_state == ST_SUM) begin
                r_ch <= r_ch + 1'b1;
            end
            if (r_state == ST_DONE) begin
                // advance the position and shift the recent pixels
                r_prev1 <= r_prev0;
                r_prev0 <= r_cur;
                if (r_end) begin
                    r_col <= '0;
                    r_row <= r_lastrow ? '0 : r_r + 1'b1;
                end else begin
                    r_col <= r_c + 1'b1;
                    r_row <= r_r;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cur     <= {i_red, i_green, i_blue};
            r_c       <= c_now;
            r_r       <= r_now;
            r_end     <= end_now;
            r_lastrow <= last_now;
        end
        if (r_state == ST_RD1) begin
            r_pm2 <= p_rdata;
            r_om1 <= o_rdata;
        end
        if (r_state == ST_RD2) begin
            r_pm1 <= p_rdata;
            r_oc  <= o_rdata;
        end
        if (r_state == ST_WR0) begin
            r_pc <= p_rdata;
        end
        if (r_state == ST_PICK && r_pend != '0) begin
            r_slot <= t_slot'(pick_idx);
        end
        if (r_state == ST_SUM) begin
            r_sum <= n_sum;
            if (r_ch == 2'd2) begin
                r_sq_v   <= {n_sum, 12'd0};
                r_sq_res <= '0;
                r_sq_bit <= ROOT_W'(1) << (ROOT_W - 1);
            end
        end
        if (r_state == ST_ROOT) begin
            if (sq_take) begin
                r_sq_v   <= r_sq_v - ROOT_W'(sq_trial);
                r_sq_res <= (r_sq_res >> 1) + 32'(r_sq_bit);
            end else begin
                r_sq_res <= r_sq_res >> 1;
            end
            r_sq_bit <= r_sq_bit >> 2;
        end
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    logic slot_up, slot_end;
    assign slot_up  = (r_slot == RES_UP_LEFT) || (r_slot == RES_UP_END);
    assign slot_end = (r_slot == RES_UP_END) || (r_slot == RES_CUR_END);

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = (r_state == ST_OUT);
    assign o_energy_q    = r_sq_res[15:0];
    assign o_square_sum  = r_sum;
    assign o_out_row     = 10'(slot_up ? r_r - 1'b1 : r_r);
    assign o_out_column  = 10'(slot_end ? r_c : r_c - 1'b1);
    assign o_last_of_run = (r_pend == '0);
    assign o_frame_done  = (r_slot == RES_CUR_END);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!p_we && !o_we))
        else $error("line buffer written while idle");

    a_accept_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_RD0))
        else $error("accepted pixel did not start the read sequence");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> o_last_of_run)
        else $error("frame end result not last of its run");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

endmodule

[verif/testbench.sv]
// Self-checking testbench for dual_gradient_energy: raster pixels in, energies out.
// Depends on dge_pkg and the dual_gradient_energy RTL; holds its own energy predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dge_pkg::*;

    localparam int MAX_DIM = 1024;
    localparam logic [7:0] CFG_UNUSED_INDEX = 8'd2;
    // Upper bound on the block's work for one pixel with no result still in flight
    localparam int SETTLE_CYCLES = 120;
    // Cycles with no transaction on any channel before the run is declared hung
    localparam int HANG_LIMIT = 6000;

    typedef struct packed {
        logic [15:0] energy_q;
        logic [18:0] square_sum;
        logic [9:0]  row;
        logic [9:0]  column;
        logic        last_of_run;
        logic        frame_done;
    } t_energy;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    logic [7:0] i_red, i_green, i_blue;
    logic o_out_valid;
    logic i_out_ready;
    logic [15:0] o_energy_q;
    logic [18:0] o_square_sum;
    logic [9:0] o_out_row, o_out_column;
    logic o_last_of_run, o_frame_done;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [7:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    dual_gradient_energy uut (.*);

    // Predictor state: line buffers, last two pixels, raster position, size registers
    logic [23:0] above_row [0:MAX_DIM-1];
    logic [23:0] two_above_row [0:MAX_DIM-1];
    logic [23:0] last_px, second_last_px;
    int unsigned pos_row, pos_col;
    logic [CFG_W-1:0] width_reg, height_reg;

    t_energy pending_energies[$];
    bit failed;
    int in_idle_pct, out_stall_pct;
    int out_hold_cycles;
    int quiet_cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int unsigned clamp_size(logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    function automatic logic [18:0] gradient_sum(logic [23:0] left, logic [23:0] right,
                                                 logic [23:0] up, logic [23:0] down);
        int acc;
        int dx, dy;
        acc = 0;
        for (int ch = 0; ch < 3; ch++) begin
            dx = int'(right[16-8*ch +: 8]) - int'(left[16-8*ch +: 8]);
            dy = int'(down[16-8*ch +: 8]) - int'(up[16-8*ch +: 8]);
            acc += dx * dx + dy * dy;
        end
        return acc[18:0];
    endfunction

    // Floor of sqrt(sum) in six fraction bits: integer root of sum * 4096
    function automatic logic [15:0] fixed_root(logic [18:0] sum);
        longint unsigned v, res, b;
        v = longint'(sum) << 12;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res[15:0];
    endfunction

    function automatic void push_energy(logic [18:0] sum, int unsigned row, int unsigned col,
                                        bit done);
        t_energy e;
        e.energy_q = fixed_root(sum);
        e.square_sum = sum;
        e.row = row[9:0];
        e.column = col[9:0];
        e.last_of_run = 1'b0;
        e.frame_done = done;
        pending_energies.push_back(e);
    endfunction

    // Advance the predictor by one accepted pixel and queue the energies it releases
    function automatic void predict_pixel(logic [23:0] cur);
        int unsigned w, h, c, r, k, prior_count;
        bit row_end, bottom;
        logic [23:0] p0, p1;
        t_energy e;
        w = clamp_size(width_reg);
        h = clamp_size(height_reg);
        c = (pos_col < w) ? pos_col : w - 1;
        r = (pos_row < h) ? pos_row : h - 1;
        p0 = last_px;
        p1 = second_last_px;
        row_end = (c == w - 1);
        bottom = (r == h - 1);
        prior_count = pending_energies.size();
        if (r >= 1) begin
            if (c >= 1) begin
                k = c - 1;
                push_energy(gradient_sum(above_row[k >= 1 ? k - 1 : k], above_row[k + 1],
                                         r >= 2 ? two_above_row[k] : above_row[k], p0),
                            r - 1, k, 0);
            end
            if (row_end) begin
                k = w - 1;
                push_energy(gradient_sum(above_row[k >= 1 ? k - 1 : k], above_row[k],
                                         r >= 2 ? two_above_row[k] : above_row[k], cur),
                            r - 1, k, 0);
            end
        end
        if (bottom) begin
            if (c >= 1) begin
                k = c - 1;
                push_energy(gradient_sum(k >= 1 ? p1 : p0, cur, r >= 1 ? above_row[k] : p0, p0),
                            r, k, 0);
            end
            if (row_end) begin
                k = w - 1;
                push_energy(gradient_sum(w >= 2 ? p0 : cur, cur,
                                         r >= 1 ? above_row[k] : cur, cur), r, k, 1);
            end
        end
        if (pending_energies.size() > prior_count) begin
            e = pending_energies.pop_back();
            e.last_of_run = 1'b1;
            pending_energies.push_back(e);
        end
        // Shift the line buffers: the row above moves down, this row becomes the row above
        if (c >= 1)
            two_above_row[c - 1] = above_row[c - 1];
        if (row_end)
            two_above_row[c] = above_row[c];
        if (c >= 2)
            above_row[c - 2] = p1;
        if (row_end) begin
            if (c >= 1)
                above_row[c - 1] = p0;
            above_row[c] = cur;
        end
        second_last_px = p0;
        last_px = cur;
        if (row_end) begin
            pos_col = 0;
            pos_row = bottom ? 0 : r + 1;
        end else begin
            pos_col = c + 1;
            pos_row = r;
        end
    endfunction

    // Receiver: a long hold-off wins over the random stall
    always @(posedge i_clk) begin
        if (out_hold_cycles > 0) begin
            out_hold_cycles <= out_hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    // Check each output transaction against the oldest queued energy
    always @(posedge i_clk) begin
        t_energy got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_energy_q, o_square_sum, o_out_row, o_out_column,
                    o_last_of_run, o_frame_done};
            if (pending_energies.size() == 0) begin
                failed = 1'b1;
                $display("%0t: unexpected energy q=%0d sum=%0d row=%0d col=%0d last=%0b done=%0b",
                         $time, got.energy_q, got.square_sum, got.row, got.column,
                         got.last_of_run, got.frame_done);
            end else begin
                want = pending_energies.pop_front();
                if (got !== want) begin
                    failed = 1'b1;
                    $display("%0t: mismatch expected q=%0d sum=%0d row=%0d col=%0d last=%0b done=%0b",
                             $time, want.energy_q, want.square_sum, want.row, want.column,
                             want.last_of_run, want.frame_done);
                    $display("%0t:          actual   q=%0d sum=%0d row=%0d col=%0d last=%0b done=%0b",
                             $time, got.energy_q, got.square_sum, got.row, got.column,
                             got.last_of_run, got.frame_done);
                end
            end
        end
    end

    // Watchdog: count cycles in which no transaction moves on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one pixel, hold it until accepted, then maybe leave a gap
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        i_in_valid <= 1'b1;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        predict_pixel({r, g, b});
        if ($urandom_range(99) < in_idle_pct) begin
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Wait for every queued energy, then let a pixel without results finish
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_energies.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] index, logic [CFG_W-1:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (index == CFG_IMAGE_WIDTH)
            width_reg = data;
        else if (index == CFG_IMAGE_HEIGHT)
            height_reg = data;
    endtask

    task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
    endtask

    // Send a run of pixels; extreme runs alternate black and white per channel
    task automatic send_pixels(int unsigned n, bit extreme);
        for (int unsigned i = 0; i < n; i++) begin
            if (extreme)
                send_pixel(i[0] ? 8'hFF : 8'h00, i[1] ? 8'hFF : 8'h00, i[0] ? 8'h00 : 8'hFF);
            else
                send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'($urandom_range(255)));
        end
    endtask

    // Send one whole frame
    task automatic send_frame(bit extreme);
        send_pixels(clamp_size(width_reg) * clamp_size(height_reg), extreme);
    endtask

    // Tiny frames: single pixel, single row, single column, black/white steps,
    // zero sizes taken as one, an unused register index
    task automatic test_small_frames();
        set_size(1, 1);
        send_frame(1);
        set_size(0, 0);
        send_frame(0);
        write_reg(CFG_UNUSED_INDEX, '1);
        set_size(2, 2);
        send_frame(1);
        set_size(3, 1);
        send_frame(1);
        set_size(1, 3);
        send_frame(1);
        set_size(3, 3);
        send_frame(1);
    endtask

    // Random frames, cycling through the idle and stall mixes
    task automatic test_random_frames();
        int sent;
        int mix;
        sent = 0;
        mix = 0;
        while (sent < 250) begin
            case (mix % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 62; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 62; end
                default: begin in_idle_pct = 32; out_stall_pct = 32; end
            endcase
            set_size(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 8)));
            send_frame($urandom_range(7) == 0);
            sent += clamp_size(width_reg) * clamp_size(height_reg);
            mix++;
        end
        in_idle_pct = 0;
        out_stall_pct = 0;
    endtask

    // Hold the receiver off so the block backs up, then pause until drained
    task automatic test_backpressure();
        set_size(6, 4);
        out_hold_cycles = 400;
        send_frame(0);
        drain();
        send_frame(0);
    endtask

    // Oversized values saturate to the maximum; shrink the size partway through
    // so the position saturates and the frame closes early
    task automatic test_size_limits();
        set_size(11'd2047, 11'd1);
        send_pixels(30, 0);
        set_size(11'd5, 11'd1);
        send_pixels(1, 0);
        set_size(11'd1, 11'd1100);
        send_pixels(30, 0);
        set_size(11'd1, 11'd3);
        send_pixels(1, 0);
    endtask

    initial begin
        failed = 1'b0;
        in_idle_pct = 0;
        out_stall_pct = 0;
        out_hold_cycles = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_red = '0;
        i_green = '0;
        i_blue = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        last_px = '0;
        second_last_px = '0;
        pos_row = 0;
        pos_col = 0;
        width_reg = 11'd1024;
        height_reg = 11'd1024;
        for (int i = 0; i < MAX_DIM; i++) begin
            above_row[i] = '0;
            two_above_row[i] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_small_frames();
        test_random_frames();
        test_backpressure();
        test_size_limits();
        drain();

        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

[files.f]
rtl/core/dge_pkg.sv
rtl/core/dge_ram.sv
rtl/core/dual_gradient_energy.sv
verif/testbench.sv
